### sv/esw_pkg.sv
// ----------------------------------------------------------------------------
// esw_pkg
// Shared widths, register addresses and defaults for the exact-sum window
// interval selector.
// ----------------------------------------------------------------------------
package esw_pkg;

  localparam int VALUE_W   = 16;  // defender_value
  localparam int ATT_W     = 8;   // attacker_count register
  localparam int TGT_W     = 24;  // target_strength register
  localparam int SUM_W     = 25;  // window sum: target plus one value
  localparam int COUNT_W   = 11;  // covered_count field
  localparam int S_DATA_W  = 16;  // slave tdata, whole bytes
  localparam int M_DATA_W  = 16;  // master tdata, whole bytes
  localparam int M_USER_W  = 1;   // master tuser: failed
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam int MAX_DEFENDERS_DEF = 1024;
  localparam int MAX_ATTACKERS_DEF = 128;

  // register indexes, decoded from paddr[2]
  localparam logic REG_ATTACKER_COUNT  = 1'b0;
  localparam logic REG_TARGET_STRENGTH = 1'b1;

  localparam logic [ATT_W-1:0] ATT_RESET = ATT_W'(1);
  localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(1);

endpackage

### sv/esw_ram.sv
// ----------------------------------------------------------------------------
// esw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module esw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/exact_sum_window_interval_dp_unit.sv
// ----------------------------------------------------------------------------
// exact_sum_window_interval_dp_unit
// Loads a run of unsigned values, records for each end position the length of
// the contiguous run summing exactly to target_strength, then picks exactly
// attacker_count non-overlapping runs of largest total length.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------
//  s_*      | in  | s_tvalid/tready  | tdata[15:0] defender_value, tlast is_last
//  m_*      | out | m_tvalid/tready  | tdata[10:0] covered_count, tuser failed
//  apb      | in  | psel/penable     | paddr 0 attacker_count, 4 target_strength
//
//  Each window step waits on one registered read of the value RAM. A word
//  arriving with the value store full is dropped. After a tlast word the
//  selection pass runs attacker_count rows over the loaded values; each
//  column is a run-length RAM read followed by a previous-row RAM read. No
//  rows run for a zero or too large count.
//  s_tready is high only while idle. A result waiting on m_tready does not
//  block loading of the next dataset, only the end of its selection pass.
//  rst is synchronous; no RAM clearing pass: stale entries are never read.
// ----------------------------------------------------------------------------
module exact_sum_window_interval_dp_unit #(
  parameter int MAX_DEFENDERS = esw_pkg::MAX_DEFENDERS_DEF,
  parameter int MAX_ATTACKERS = esw_pkg::MAX_ATTACKERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [esw_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] defender_value
  input  logic                          s_tlast,   // is_last
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [esw_pkg::M_DATA_W-1:0]  m_tdata,   // [10:0] covered_count, rest 0
  output logic [esw_pkg::M_USER_W-1:0]  m_tuser,   // [0] failed
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esw_pkg::APB_AW-1:0]    paddr,
  input  logic [esw_pkg::APB_DW-1:0]    pwdata,
  output logic [esw_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import esw_pkg::*;

  // AW indexes the value/run stores, CW counts 0..MAX_DEFENDERS
  localparam int AW = (MAX_DEFENDERS > 1) ? $clog2(MAX_DEFENDERS) : 1;
  localparam int CW = $clog2(MAX_DEFENDERS + 1);
  localparam int RW = CW + 1;  // DP row entry: {unreachable, length}

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for a word
    S_CHK,      // window too large? issue read of the start value
    S_SUB,      // drop start value from the window
    S_REC,      // record run length for this position
    S_DPSTART,  // special cases of the selection pass
    S_ROW,      // open a DP row
    S_RDLEN,    // read run length ending at column j
    S_RDPREV,   // read previous row at j - len
    S_UPD,      // update current row at j
    S_OUT       // hand result to output register
  } state_t;

  state_t state;

  // config registers
  logic [ATT_W-1:0] attacker_count;
  logic [TGT_W-1:0] target_strength;

  // dataset state
  logic [CW-1:0]    loaded_count;
  logic [CW-1:0]    window_start;
  logic [SUM_W-1:0] window_sum;
  logic             last_q;

  // selection state
  logic [ATT_W-1:0] row_idx;
  logic [CW-1:0]    col;
  logic             row_sel;    // current row lives in RAM row_sel
  logic             first_row;  // previous row is all zero
  logic             len_ok;
  logic [CW-1:0]    len_q;
  logic             best_unr;
  logic [CW-1:0]    best_val;
  logic             res_fail;
  logic [CW-1:0]    res_count;

  // RAM ports
  logic             val_we;
  logic [VALUE_W-1:0] val_rdata;
  logic             run_we;
  logic [CW-1:0]    run_wdata;
  logic [CW-1:0]    run_rdata;
  logic             row_we;
  logic [CW-1:0]    row_waddr;
  logic [RW-1:0]    row_wdata;
  logic [CW-1:0]    row_raddr;
  logic [RW-1:0]    row0_rdata;
  logic [RW-1:0]    row1_rdata;
  logic [RW-1:0]    prev_rdata;

  // combinational helpers
  logic             s_acc;
  logic             cfg_wr;
  logic             full;
  logic             win_open;   // start <= pos
  logic [SUM_W-1:0] target_ext;
  logic             len_ok_next;
  logic             prev_ok;
  logic [CW-1:0]    prev_val;
  logic [CW-1:0]    take;
  logic             take_wins;
  logic             new_unr;
  logic [CW-1:0]    new_val;
  logic             row_last;
  logic             out_free;
  logic             att_too_big;

  assign s_tready    = (state == S_IDLE);
  assign s_acc       = s_tvalid && s_tready;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign full        = (loaded_count == CW'(MAX_DEFENDERS));
  assign win_open    = (window_start <= loaded_count);
  assign target_ext  = SUM_W'(target_strength);
  assign out_free    = !m_tvalid || m_tready;
  assign att_too_big = (32'(attacker_count) > 32'(MAX_ATTACKERS));

  always_comb begin
    case (paddr[2])
      REG_ATTACKER_COUNT:  prdata = APB_DW'(attacker_count);
      REG_TARGET_STRENGTH: prdata = APB_DW'(target_strength);
      default:             prdata = '0;
    endcase
  end

  // window datapath
  assign val_we    = s_acc && !full;
  assign run_we    = (state == S_REC);
  assign run_wdata = (window_sum == target_ext && win_open)
                   ? CW'(loaded_count - window_start + CW'(1)) : '0;

  // DP datapath
  assign len_ok_next = (run_rdata != '0) && (run_rdata <= col);
  assign row_raddr   = len_ok_next ? CW'(col - run_rdata) : '0;
  assign prev_rdata  = row_sel ? row0_rdata : row1_rdata;
  assign prev_ok     = first_row || !prev_rdata[CW];
  assign prev_val    = first_row ? '0 : prev_rdata[CW-1:0];
  assign take        = CW'(prev_val + len_q);
  assign take_wins   = len_ok && prev_ok && (best_unr || take > best_val);
  assign new_unr     = take_wins ? 1'b0 : best_unr;
  assign new_val     = take_wins ? take : best_val;
  assign row_last    = (col == loaded_count);

  always_comb begin
    row_we    = 1'b0;
    row_waddr = col;
    row_wdata = {new_unr, new_val};
    case (state)
      S_ROW: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = {1'b1, {CW{1'b0}}};
      end
      S_UPD:   row_we = 1'b1;
      default: row_we = 1'b0;
    endcase
  end

  esw_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DEFENDERS), .AW(AW)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (loaded_count[AW-1:0]),
    .wdata (s_tdata[VALUE_W-1:0]),
    .raddr (window_start[AW-1:0]),
    .rdata (val_rdata)
  );

  esw_ram #(.WIDTH(CW), .DEPTH(MAX_DEFENDERS), .AW(AW)) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (loaded_count[AW-1:0]),
    .wdata (run_wdata),
    .raddr (AW'(col - CW'(1))),
    .rdata (run_rdata)
  );

  esw_ram #(.WIDTH(RW), .DEPTH(MAX_DEFENDERS + 1), .AW(CW)) u_row0_ram (
    .clk   (clk),
    .we    (row_we && !row_sel),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row0_rdata)
  );

  esw_ram #(.WIDTH(RW), .DEPTH(MAX_DEFENDERS + 1), .AW(CW)) u_row1_ram (
    .clk   (clk),
    .we    (row_we && row_sel),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row1_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      attacker_count  <= ATT_RESET;
      target_strength <= TGT_RESET;
      loaded_count    <= '0;
      window_start    <= '0;
      window_sum      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_ATTACKER_COUNT:  attacker_count  <= pwdata[ATT_W-1:0];
          REG_TARGET_STRENGTH: target_strength <= pwdata[TGT_W-1:0];
          default: ;
        endcase
      end

      // a new word replaces the old one in the cycle it is taken
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_acc) begin
            last_q <= s_tlast;
            if (!full) begin
              window_sum <= window_sum + SUM_W'(s_tdata[VALUE_W-1:0]);
              state      <= S_CHK;
            end else if (s_tlast) begin
              state <= S_DPSTART;
            end
          end
        end
        S_CHK: begin
          // value RAM reads window_start this edge
          if (window_sum > target_ext && win_open) begin
            state <= S_SUB;
          end else begin
            state <= S_REC;
          end
        end
        S_SUB: begin
          window_sum   <= window_sum - SUM_W'(val_rdata);
          window_start <= window_start + CW'(1);
          state        <= S_CHK;
        end
        S_REC: begin
          loaded_count <= loaded_count + CW'(1);
          state        <= last_q ? S_DPSTART : S_IDLE;
        end
        S_DPSTART: begin
          if (att_too_big || (attacker_count != '0 && loaded_count == '0)) begin
            res_fail  <= 1'b1;
            res_count <= '0;
            state     <= S_OUT;
          end else if (attacker_count == '0) begin
            res_fail  <= 1'b0;
            res_count <= '0;
            state     <= S_OUT;
          end else begin
            row_idx   <= ATT_W'(1);
            row_sel   <= 1'b0;
            first_row <= 1'b1;
            state     <= S_ROW;
          end
        end
        S_ROW: begin
          best_unr <= 1'b1;
          best_val <= '0;
          col      <= CW'(1);
          state    <= S_RDLEN;
        end
        S_RDLEN: begin
          state <= S_RDPREV;
        end
        S_RDPREV: begin
          len_ok <= len_ok_next;
          len_q  <= run_rdata;
          state  <= S_UPD;
        end
        S_UPD: begin
          best_unr <= new_unr;
          best_val <= new_val;
          if (row_last) begin
            if (row_idx == attacker_count) begin
              res_fail  <= new_unr;
              res_count <= new_unr ? '0 : new_val;
              state     <= S_OUT;
            end else begin
              row_idx   <= row_idx + ATT_W'(1);
              row_sel   <= !row_sel;
              first_row <= 1'b0;
              state     <= S_ROW;
            end
          end else begin
            col   <= col + CW'(1);
            state <= S_RDLEN;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tdata      <= M_DATA_W'(COUNT_W'(res_count));
            m_tuser      <= M_USER_W'(res_fail);
            loaded_count <= '0;
            window_start <= '0;
            window_sum   <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/esw_checker.sv
// ----------------------------------------------------------------------------
// esw_checker
// Port-level checks for the exact-sum window interval selector.
// ----------------------------------------------------------------------------
module esw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [esw_pkg::M_DATA_W-1:0]  m_tdata,
  input logic [esw_pkg::M_USER_W-1:0]  m_tuser,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [esw_pkg::APB_AW-1:0]    paddr,
  input logic [esw_pkg::APB_DW-1:0]    pwdata,
  input logic [esw_pkg::APB_DW-1:0]    prdata,
  input logic                          pready
);

  import esw_pkg::*;

  // no result word survives reset
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // a failed result carries a zero count
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("failed result with nonzero count");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result word changed while stalled");

  // written attacker_count reads back on the next cycle at the same address
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2] == REG_ATTACKER_COUNT) |=>
      (paddr[2] != REG_ATTACKER_COUNT ||
       prdata == APB_DW'($past(pwdata[ATT_W-1:0]))))
    else $error("attacker_count readback mismatch");

endmodule

bind exact_sum_window_interval_dp_unit esw_checker u_esw_checker (.*);

### tb/esw_cover_checker.sv
// ----------------------------------------------------------------------------
// esw_cover_checker
// Watches the configuration bus and both streams of the exact-sum window
// interval selector, predicts the covered count of every dataset and compares
// each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module esw_cover_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [esw_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] defender_value
  input  logic                          s_tlast,   // is_last
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [esw_pkg::M_DATA_W-1:0]  m_tdata,   // [10:0] covered_count, rest 0
  input  logic [esw_pkg::M_USER_W-1:0]  m_tuser,   // [0] failed
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esw_pkg::APB_AW-1:0]    paddr,
  input  logic [esw_pkg::APB_DW-1:0]    pwdata,
  input  logic                          pready,
  output int                            outstanding,
  output int                            mismatches
);
  import esw_pkg::*;

  localparam int DEPTH = MAX_DEFENDERS_DEF;
  localparam int IW    = $clog2(DEPTH);      // value / run index
  localparam int RIW   = $clog2(DEPTH + 1);  // DP row index

  localparam logic signed [COUNT_W:0] UNREACH = '1;  // -1

  typedef struct packed {
    logic [COUNT_W-1:0] covered;
    logic               failed;
  } cover_t;

  cover_t covers_due[$];

  logic [ATT_W-1:0]          att_reg;
  logic [TGT_W-1:0]          tgt_reg;
  logic [VALUE_W-1:0]        values   [DEPTH];
  logic [COUNT_W-1:0]        run_len  [DEPTH];
  logic [SUM_W-1:0]          wsum;
  logic [COUNT_W-1:0]        wstart;
  logic [COUNT_W-1:0]        loaded;
  logic signed [COUNT_W:0]   prev_row [DEPTH+1];  // -1: not reachable
  logic signed [COUNT_W:0]   cur_row  [DEPTH+1];

  task automatic report(string what);
    $display("esw check @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_dataset();
    foreach (run_len[k]) run_len[k] = '0;
    wsum   = '0;
    wstart = '0;
    loaded = '0;
  endfunction

  // two-pointer window: keep the run ending at pos whose sum stays at or
  // below the target, record its length when the sum hits the target
  function automatic void load_value(logic [VALUE_W-1:0] v);
    logic [COUNT_W-1:0] pos;
    if (loaded < COUNT_W'(DEPTH)) begin
      pos                 = loaded;
      values[pos[IW-1:0]] = v;
      wsum                = wsum + SUM_W'(v);
      while (wsum > SUM_W'(tgt_reg) && wstart <= pos) begin
        wsum   = wsum - SUM_W'(values[wstart[IW-1:0]]);
        wstart = wstart + COUNT_W'(1);
      end
      if (wsum == SUM_W'(tgt_reg) && wstart <= pos)
        run_len[pos[IW-1:0]] = pos - wstart + COUNT_W'(1);
      else
        run_len[pos[IW-1:0]] = '0;
      loaded = pos + COUNT_W'(1);
    end
  endfunction

  // exactly att_reg disjoint runs, largest total length
  function automatic cover_t pick_runs();
    int                      i;
    int                      j;
    logic [COUNT_W-1:0]      len;
    logic signed [COUNT_W:0] best;
    logic signed [COUNT_W:0] take;
    cover_t                  res;
    res = '0;
    if (att_reg > ATT_W'(MAX_ATTACKERS_DEF)) begin
      res.failed = 1'b1;
      return res;
    end
    for (j = 0; j <= int'(loaded); j++) prev_row[RIW'(j)] = '0;
    for (i = 1; i <= int'(att_reg); i++) begin
      cur_row[0] = UNREACH;
      for (j = 1; j <= int'(loaded); j++) begin
        len  = run_len[IW'(j - 1)];
        best = cur_row[RIW'(j - 1)];
        if (len != '0 && int'(len) <= j && prev_row[RIW'(j - int'(len))] != UNREACH) begin
          take = prev_row[RIW'(j - int'(len))] + $signed({1'b0, len});
          if (take > best) best = take;
        end
        cur_row[RIW'(j)] = best;
      end
      for (j = 0; j <= int'(loaded); j++) prev_row[RIW'(j)] = cur_row[RIW'(j)];
    end
    if (prev_row[loaded] < 0) res.failed = 1'b1;
    else res.covered = prev_row[loaded][COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    cover_t want;
    if (rst) begin
      att_reg = ATT_RESET;
      tgt_reg = TGT_RESET;
      clear_dataset();
      covers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ATTACKER_COUNT) att_reg = pwdata[ATT_W-1:0];
        else tgt_reg = pwdata[TGT_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        load_value(s_tdata[VALUE_W-1:0]);
        if (s_tlast) begin
          covers_due.push_back(pick_runs());
          clear_dataset();
        end
      end
      if (m_tvalid && m_tready) begin
        if (covers_due.size() == 0) begin
          report("result word with no dataset closed");
        end else begin
          want = covers_due.pop_front();
          if (m_tdata !== M_DATA_W'(want.covered))
            report($sformatf("covered_count got %0d want %0d", m_tdata, want.covered));
          if (m_tuser[0] !== want.failed)
            report($sformatf("failed got %b want %b", m_tuser[0], want.failed));
        end
      end
    end
    outstanding <= covers_due.size();
  end

endmodule

### tb/exact_sum_window_interval_dp_unit_tb.sv
// ----------------------------------------------------------------------------
// exact_sum_window_interval_dp_unit_tb
// Drives datasets of values into the selector, rewrites both registers between
// phases and lets the checker predict and compare every covered-count word.
// ----------------------------------------------------------------------------
module exact_sum_window_interval_dp_unit_tb;
  import esw_pkg::*;

  // longest honest quiet stretch: 128 rows over a 20-value set, or a few
  // rows over a full 1024-value store, plus receiver stalls
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_WORDS    = 36;
  localparam int BIG_PHASE      = 5;
  localparam int BIG_WORDS      = 1030;  // overfills the value store

  localparam logic [APB_AW-1:0] ADDR_ATTACKERS = {REG_ATTACKER_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_TARGET    = {REG_TARGET_STRENGTH, 2'b00};

  // idle mixes, cycled per phase: none, sender gaps, receiver stalls, both light
  localparam int SEND_IDLE [4] = '{0, 62, 0, 7};
  localparam int RECV_STALL[4] = '{0, 0, 62, 7};

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata  = '0;   // [15:0] defender_value
  logic                 s_tlast  = 1'b0; // is_last
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;         // [10:0] covered_count, rest 0
  logic [M_USER_W-1:0]  m_tuser;         // [0] failed
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [APB_AW-1:0]    paddr    = '0;
  logic [APB_DW-1:0]    pwdata   = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int outstanding;
  int mismatches;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int quiet_count = 0;

  exact_sum_window_interval_dp_unit DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  esw_cover_checker cover_chk (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .outstanding, .mismatches
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any handshake on any port restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("exact_sum_window_interval_dp_unit_tb: done, errors");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // both registers back to back; psel stays up between the two transfers.
  // junk above the register width must be dropped by the block
  task automatic set_config(logic [ATT_W-1:0] att, logic [TGT_W-1:0] tgt);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ATTACKERS;
    pwdata  <= {24'($urandom), att};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    paddr   <= ADDR_TARGET;
    pwdata  <= {8'($urandom), tgt};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one word; returns at the edge that accepted it with tvalid still high
  task automatic send_value(logic [VALUE_W-1:0] v, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // block idle: no result pending, loader ready, then a short pause
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || !s_tready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly values no larger than the target so exact sums show up often;
  // some zeros and full-range noise
  function automatic logic [VALUE_W-1:0] pick_value(logic [TGT_W-1:0] tgt);
    int hi;
    int roll;
    roll = $urandom_range(99);
    hi   = (tgt > 65535) ? 65535 : ((tgt == 0) ? 1 : int'(tgt));
    if (roll < 3) return '0;
    if (roll < 13) return VALUE_W'($urandom_range(65535));
    if (roll < 55) return VALUE_W'($urandom_range(hi, 1));
    return VALUE_W'($urandom_range((hi + 2) / 3, 1));
  endfunction

  initial begin
    int               ph;
    int               k;
    int               n;
    int               sent;
    int               roll;
    logic [ATT_W-1:0] att;
    logic [TGT_W-1:0] tgt;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed ----
    // reset config: one run of sum 1
    send_value(16'd1, 1'b1);
    settle();
    // zero target: zero values form runs, a nonzero value empties the window
    set_config(8'd2, 24'd0);
    send_value(16'd0, 1'b0);
    send_value(16'd0, 1'b0);
    send_value(16'd7, 1'b0);
    send_value(16'd0, 1'b1);
    settle();
    // zero runs asked: covered 0, not failed
    set_config(8'd0, 24'd65535);
    send_value(16'hFFFF, 1'b0);
    send_value(16'd1, 1'b1);
    settle();
    // count above the limit: failed
    set_config(8'hFF, 24'd5);
    send_value(16'd5, 1'b1);
    settle();
    // largest allowed count, largest target: no run, failed
    set_config(8'd128, 24'hFFFFFF);
    repeat (3) send_value(16'hFFFF, 1'b0);
    send_value(16'hFFFF, 1'b1);
    settle();
    // target lowered mid-dataset; window shrinks onto the new target
    set_config(8'd3, 24'd10);
    send_value(16'd4, 1'b0);
    send_value(16'd6, 1'b0);
    send_value(16'd10, 1'b0);
    settle();
    set_config(8'd3, 24'd6);
    send_value(16'd6, 1'b0);
    send_value(16'd3, 1'b0);
    send_value(16'd3, 1'b0);
    send_value(16'd1, 1'b1);

    // ---- random phases ----
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      idle_pct  = SEND_IDLE[2'(ph)];
      stall_pct = RECV_STALL[2'(ph)];

      roll = $urandom_range(99);
      if (roll < 6)       att = 8'd0;
      else if (roll < 12) att = 8'd128;
      else if (roll < 18) att = ATT_W'($urandom_range(255, 129));
      else if (roll < 45) att = ATT_W'($urandom_range(20, 5));
      else                att = ATT_W'($urandom_range(4, 1));
      roll = $urandom_range(99);
      if (roll < 8)       tgt = 24'd0;
      else if (roll < 14) tgt = 24'hFFFFFF;
      else if (roll < 30) tgt = TGT_W'($urandom_range(24'hFFFFFF));
      else if (roll < 50) tgt = TGT_W'($urandom_range(3000, 41));
      else                tgt = TGT_W'($urandom_range(40, 1));

      if (ph == BIG_PHASE) begin
        // full store with runs everywhere; the last few words are dropped
        // and the closing mark rides on a dropped word
        att = ATT_W'($urandom_range(4, 1));
        tgt = TGT_W'($urandom_range(12, 4));
        set_config(att, tgt);
        for (k = 0; k < BIG_WORDS; k++)
          send_value(VALUE_W'($urandom_range(4, 1)), k == BIG_WORDS - 1);
      end else begin
        set_config(att, tgt);
      end

      sent = 0;
      while (sent < PHASE_WORDS) begin
        n = $urandom_range(20, 1);
        for (k = 0; k < n; k++) send_value(pick_value(tgt), k == n - 1);
        sent += n;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("exact_sum_window_interval_dp_unit_tb: done, clean");
    end else begin
      $display("exact_sum_window_interval_dp_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
